// File: rtl/dqvs_pkg.sv
// Shared constants and types for the deque with value search.
`default_nettype none
package dqvs_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    localparam int IN_W  = 40;
    localparam int OUT_W = 16;

    localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DROP_HEAD = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP_TAIL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND_HEAD = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FIND_TAIL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;
        logic search_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_search;
        logic search_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: rtl/dqvs_ctrl.sv
// Controller state machine: accept, search walk, result hand-off.
`default_nettype none
module dqvs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire dqvs_pkg::sts_t sts,
    output dqvs_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.accept      = 1'b0;
        cmd.search_step = 1'b0;
        cmd.finish      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.in_search ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.search_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dqvs_dp.sv
// Datapath: entry ring, head and count, search walk and output register.
`default_nettype none
module dqvs_dp #(
    parameter int DEPTH = dqvs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [dqvs_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [dqvs_pkg::OUT_W-1:0]      m_tdata,
    input  wire dqvs_pkg::cmd_t             cmd,
    output dqvs_pkg::sts_t                  sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [dqvs_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [dqvs_pkg::ACTION_W-1:0] action_reg;
    logic [dqvs_pkg::VALUE_W-1:0]  value_reg;
    logic [CW-1:0] idx_reg;
    logic          pend_reg;
    logic [CW-1:0] pend_idx_reg;
    logic          found_reg;
    logic [dqvs_pkg::POS_W-1:0]    res_pos_reg;
    logic [dqvs_pkg::STATUS_W-1:0] res_status_reg;
    logic [dqvs_pkg::VALUE_W-1:0]  rd_data_reg;
    logic          out_valid_reg;
    logic [dqvs_pkg::OUT_W-1:0]    out_data_reg;

    logic [dqvs_pkg::ACTION_W-1:0] in_action;
    logic [dqvs_pkg::VALUE_W-1:0]  in_value;
    logic [AW-1:0] rd_offset;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] head_inc;
    logic          issue;
    logic          hit;
    logic          wr_en;
    logic [CW+dqvs_pkg::POS_W-1:0] pos_ext;
    logic [CW+dqvs_pkg::OCC_W-1:0] occ_ext;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, h} + {1'b0, off};
        if (sum >= DEPTH_A)
        begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign in_action = s_tdata[dqvs_pkg::ACTION_W-1:0];
    assign in_value  = s_tdata[dqvs_pkg::ACTION_W +: dqvs_pkg::VALUE_W];

    assign issue = cmd.search_step && (idx_reg < count_reg) && !found_reg && !hit;
    assign hit   = pend_reg && (rd_data_reg == value_reg);

    always_comb
    begin
        logic [CW-1:0] back_off;
        back_off  = count_reg - CW'(1) - idx_reg;
        rd_offset = (action_reg == dqvs_pkg::ACT_FIND_TAIL) ? back_off[AW-1:0]
                                                            : idx_reg[AW-1:0];
    end

    assign rd_addr  = ring(head_reg, rd_offset);
    assign wr_addr  = ring(head_reg, count_reg[AW-1:0]);
    assign head_inc = ring(head_reg, AW'(1));
    assign wr_en    = cmd.accept && (in_action == dqvs_pkg::ACT_APPEND) && (count_reg < DEPTH_C);

    assign sts.in_search   = (in_action == dqvs_pkg::ACT_FIND_HEAD) ||
                             (in_action == dqvs_pkg::ACT_FIND_TAIL);
    assign sts.search_done = found_reg || hit || (!pend_reg && (idx_reg >= count_reg));
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign pos_ext = {{dqvs_pkg::POS_W{1'b0}}, pend_idx_reg};
    assign occ_ext = {{dqvs_pkg::OCC_W{1'b0}}, count_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= in_action;
            value_reg  <= in_value;
        end
        if (cmd.finish)
        begin
            out_data_reg <= {4'b0, res_status_reg,
                             occ_ext[dqvs_pkg::OCC_W-1:0], res_pos_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            found_reg      <= 1'b0;
            res_pos_reg    <= '1;
            res_status_reg <= dqvs_pkg::ST_DONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                idx_reg        <= '0;
                pend_reg       <= 1'b0;
                found_reg      <= 1'b0;
                res_pos_reg    <= '1;
                res_status_reg <= dqvs_pkg::ST_DONE;
                unique case (in_action)
                    dqvs_pkg::ACT_APPEND:
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            res_status_reg <= dqvs_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    dqvs_pkg::ACT_DROP_HEAD:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_reg <= dqvs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            head_reg  <= head_inc;
                            count_reg <= count_reg - CW'(1);
                        end
                    end
                    dqvs_pkg::ACT_DROP_TAIL:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_reg <= dqvs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_reg <= count_reg - CW'(1);
                        end
                    end
                    dqvs_pkg::ACT_CLEAR:
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.search_step)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    idx_reg      <= idx_reg + CW'(1);
                    pend_idx_reg <= idx_reg;
                end
                if (hit && !found_reg)
                begin
                    found_reg   <= 1'b1;
                    res_pos_reg <= pos_ext[dqvs_pkg::POS_W-1:0];
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("element count above depth");

    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search_step && hit) |=> found_reg)
        else $error("search hit not recorded");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");

    a_no_issue_found: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> !issue)
        else $error("read issued after a match");

endmodule
`default_nettype wire

// File: rtl/deque_with_value_search.sv
// Top level: deque of signed 32-bit values with front and back search.
//
// Input beat (s_*): action and value. Every accepted beat gives exactly one
// output beat (m_*) with position, occupancy and status, in order.
// Append, drop front, drop back, clear and unused codes go from accept
// straight to the finish state. A search walks the held entries one per
// cycle through the registered memory read port until a match or the end
// of the entries, then moves to the finish state. In the finish state the
// result register loads once it is free.
// One beat is worked on at a time; s_tready is high only while idle.
// The result sits in an output register, so the next beat is accepted
// while the previous result still waits for m_tready. If the receiver
// stalls, the finished result of the following beat is held until the
// output register frees up.
// Reset clears head, count and the control state; stored entries are not
// cleared and are read only after they have been written.
`default_nettype none
module deque_with_value_search #(
    parameter int DEPTH = dqvs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [2:0] action, [34:3] value, [39:35] zero
    input  wire logic [dqvs_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [4:0] position, [9:5] occupancy, [11:10] status, [15:12] zero
    output logic [dqvs_pkg::OUT_W-1:0]      m_tdata
);

    dqvs_pkg::cmd_t cmd;
    dqvs_pkg::sts_t sts;

    dqvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dqvs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire
